FILE: hw/rtl/fcd_pkg.sv
// Package: shared constants for the fractional clock divider calculator.
package fcd_pkg;

    localparam int RATE_BITS_DEF     = 32;
    localparam int MAX_DIV_WIDTH_DEF = 16;

    localparam int UART_ENB_BIT    = 24;
    localparam int OVERRIDE_OFFSET = 6;

    localparam int CFG_ADDR_W = 5;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DIV_WIDTH    = 3'd0;
    localparam logic [2:0] REG_FRAC_BITS    = 3'd1;
    localparam logic [2:0] REG_FIELD_SHIFT  = 3'd2;
    localparam logic [2:0] REG_INT_ONLY     = 3'd3;
    localparam logic [2:0] REG_ROUND_UP     = 3'd4;
    localparam logic [2:0] REG_UART_ENABLE  = 3'd5;
    localparam logic [2:0] REG_FIXED_OVR    = 3'd6;

    // Reset values
    localparam logic [4:0] RST_DIV_WIDTH   = 5'd8;
    localparam logic [2:0] RST_FRAC_BITS   = 3'd1;
    localparam logic [4:0] RST_FIELD_SHIFT = 5'd0;

endpackage

FILE: hw/rtl/fcd_ifs.sv
// Interfaces: request and result channels of the divider calculator.
interface fcd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] target_rate;
    logic [31:0] src_rate;
    logic [31:0] current_word;

    modport source (output valid, target_rate, src_rate, current_word, input ready);
    modport sink   (input valid, target_rate, src_rate, current_word, output ready);
endinterface

interface fcd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] div_field;
    logic        rate_error;
    logic [31:0] rounded_rate;
    logic [31:0] new_word;
    logic [31:0] current_rate;

    modport source (output valid, div_field, rate_error, rounded_rate, new_word, current_rate,
                    input ready);
    modport sink   (input valid, div_field, rate_error, rounded_rate, new_word, current_rate,
                    output ready);
endinterface

FILE: hw/rtl/fcd_div_cell.sv
// One restoring-division step: one quotient bit per cell, registered.
module fcd_div_cell #(
    parameter int N  = 40,
    parameter int D  = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [D-1:0]  i_rem,
    input  logic [N-1:0]  i_numq,
    input  logic [D-1:0]  i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [D-1:0]  o_rem,
    output logic [N-1:0]  o_numq,
    output logic [D-1:0]  o_den,
    output logic [SW-1:0] o_side
);

    logic          r_valid;
    logic [D-1:0]  r_rem;
    logic [N-1:0]  r_numq;
    logic [D-1:0]  r_den;
    logic [SW-1:0] r_side;

    logic [D:0]    t;
    logic [D:0]    diff;
    logic          ge;
    logic [D-1:0]  n_rem;
    logic [N-1:0]  n_numq;

    // shift in next dividend bit, trial subtract
    always_comb begin
        t      = {i_rem, i_numq[N-1]};
        diff   = t - {1'b0, i_den};
        ge     = (t >= {1'b0, i_den});
        n_rem  = ge ? diff[D-1:0] : t[D-1:0];
        n_numq = {i_numq[N-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_numq <= n_numq;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_numq  = r_numq;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

FILE: hw/rtl/fcd_div_chain.sv
// Pipelined divider: a row of N division cells, one quotient bit each.
module fcd_div_chain #(
    parameter int N  = 40,
    parameter int D  = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [N-1:0]  i_num,
    input  logic [D-1:0]  i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [N-1:0]  o_quo,
    output logic [D-1:0]  o_rem,
    output logic [SW-1:0] o_side
);

    logic          s_valid [0:N];
    logic [D-1:0]  s_rem   [0:N];
    logic [N-1:0]  s_numq  [0:N];
    logic [D-1:0]  s_den   [0:N];
    logic [SW-1:0] s_side  [0:N];

    assign s_valid[0] = i_valid;
    assign s_rem[0]   = '0;
    assign s_numq[0]  = i_num;
    assign s_den[0]   = i_den;
    assign s_side[0]  = i_side;

    for (genvar g = 0; g < N; g++) begin : g_cell
        fcd_div_cell #(.N(N), .D(D), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (s_valid[g]),
            .i_rem   (s_rem[g]),
            .i_numq  (s_numq[g]),
            .i_den   (s_den[g]),
            .i_side  (s_side[g]),
            .o_valid (s_valid[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_numq  (s_numq[g+1]),
            .o_den   (s_den[g+1]),
            .o_side  (s_side[g+1])
        );
    end

    assign o_valid = s_valid[N];
    assign o_quo   = s_numq[N];
    assign o_rem   = s_rem[N];
    assign o_side  = s_side[N];

endmodule

FILE: hw/rtl/frac_clock_divider_calc.sv
// Pipeline: division cell row, field register, two parallel cell rows, output register.
// Throughput: one request per cycle while not held; one quotient bit per cell.
// The whole pipeline holds when the output register is full and not taken.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// Configuration registers are written through the APB-style port.
module frac_clock_divider_calc #(
    parameter int RATE_BITS     = fcd_pkg::RATE_BITS_DEF,
    parameter int MAX_DIV_WIDTH = fcd_pkg::MAX_DIV_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fcd_in_if.sink                        i_in,
    fcd_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int R   = RATE_BITS;
    localparam int W   = MAX_DIV_WIDTH;
    localparam int N1  = R + 8;
    localparam int QW  = N1 + 7;
    localparam int N2  = R + 7;
    localparam int D2  = W + 8;
    localparam int SW1 = R + 33;
    localparam int SW2 = W + R + 2;

    // ---------------- configuration registers ----------------
    logic [4:0] r_div_width;
    logic [2:0] r_frac_bits;
    logic [4:0] r_field_shift;
    logic       r_int_only;
    logic       r_round_up;
    logic       r_uart_en;
    logic       r_fixed_ovr;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_width   <= fcd_pkg::RST_DIV_WIDTH;
            r_frac_bits   <= fcd_pkg::RST_FRAC_BITS;
            r_field_shift <= fcd_pkg::RST_FIELD_SHIFT;
            r_int_only    <= 1'b0;
            r_round_up    <= 1'b0;
            r_uart_en     <= 1'b0;
            r_fixed_ovr   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                fcd_pkg::REG_DIV_WIDTH:   r_div_width   <= pwdata[4:0];
                fcd_pkg::REG_FRAC_BITS:   r_frac_bits   <= pwdata[2:0];
                fcd_pkg::REG_FIELD_SHIFT: r_field_shift <= pwdata[4:0];
                fcd_pkg::REG_INT_ONLY:    r_int_only    <= pwdata[0];
                fcd_pkg::REG_ROUND_UP:    r_round_up    <= pwdata[0];
                fcd_pkg::REG_UART_ENABLE: r_uart_en     <= pwdata[0];
                fcd_pkg::REG_FIXED_OVR:   r_fixed_ovr   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            fcd_pkg::REG_DIV_WIDTH:   prdata = {27'd0, r_div_width};
            fcd_pkg::REG_FRAC_BITS:   prdata = {29'd0, r_frac_bits};
            fcd_pkg::REG_FIELD_SHIFT: prdata = {27'd0, r_field_shift};
            fcd_pkg::REG_INT_ONLY:    prdata = {31'd0, r_int_only};
            fcd_pkg::REG_ROUND_UP:    prdata = {31'd0, r_round_up};
            fcd_pkg::REG_UART_ENABLE: prdata = {31'd0, r_uart_en};
            fcd_pkg::REG_FIXED_OVR:   prdata = {31'd0, r_fixed_ovr};
            default:                  prdata = '0;
        endcase
    end

    // field mask from saturated width
    logic [4:0] wd;
    logic [W:0] one_sh;
    logic [W:0] mask_full;
    logic [W-1:0] mask;

    always_comb begin
        wd        = (32'(r_div_width) > 32'(W)) ? 5'(W) : r_div_width;
        one_sh    = (W+1)'(1) << wd;
        mask_full = one_sh - (W+1)'(1);
        mask      = mask_full[W-1:0];
    end

    // ---------------- pipeline control ----------------
    logic r_o_valid;
    logic en;

    assign en          = !r_o_valid || o_out.ready;
    assign i_in.ready  = en;

    // ---------------- first divider: parent*M / target ----------------
    logic [R-1:0]   in_tgt;
    logic [R-1:0]   in_par;
    logic [N1-1:0]  num1;
    logic [SW1-1:0] side1_in;

    always_comb begin
        in_tgt   = R'(i_in.target_rate);
        in_par   = R'(i_in.src_rate);
        num1     = r_int_only ? N1'(in_par) : (N1'(in_par) << r_frac_bits);
        if (r_round_up && (in_tgt != '0)) begin
            num1 = num1 + N1'(in_tgt) - N1'(1);
        end
        side1_in = {(in_tgt == '0), in_par, i_in.current_word};
    end

    logic           v1;
    logic [N1-1:0]  q1;
    logic [R-1:0]   rem1;
    logic [SW1-1:0] side1;

    fcd_div_chain #(.N(N1), .D(R), .SW(SW1)) u_div_field (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_num   (num1),
        .i_den   (in_tgt),
        .i_side  (side1_in),
        .o_valid (v1),
        .o_quo   (q1),
        .o_rem   (rem1),
        .o_side  (side1)
    );

    // ---------------- field stage ----------------
    logic          s1_tz;
    logic [R-1:0]  s1_par;
    logic [31:0]   s1_cur;
    logic [QW-1:0] qw;
    logic [QW-1:0] mulw;
    logic [QW-1:0] dq;
    logic          below;
    logic          n_p_err;
    logic [W-1:0]  n_p_field;
    logic [W-1:0]  n_p_curf;

    always_comb begin
        {s1_tz, s1_par, s1_cur} = side1;
        qw        = r_int_only ? (QW'(q1) << r_frac_bits) : QW'(q1);
        mulw      = QW'(1) << r_frac_bits;
        below     = qw < mulw;
        dq        = qw - mulw;
        n_p_err   = !s1_tz && !below && (dq > QW'(mask));
        n_p_field = (s1_tz || below || n_p_err) ? '0 : dq[W-1:0];
        n_p_curf  = W'(s1_cur >> r_field_shift) & mask;
    end

    logic          r_p_valid;
    logic          r_p_err;
    logic          r_p_tz;
    logic [W-1:0]  r_p_field;
    logic [W-1:0]  r_p_curf;
    logic [R-1:0]  r_p_par;
    logic [31:0]   r_p_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_err   <= n_p_err;
            r_p_tz    <= s1_tz;
            r_p_field <= n_p_field;
            r_p_curf  <= n_p_curf;
            r_p_par   <= s1_par;
            r_p_cur   <= s1_cur;
        end
    end

    // ---------------- second dividers: achievable and current rate ----------------
    logic [N2-1:0]  num2;
    logic [D2-1:0]  mul2;
    logic [D2-1:0]  den2a;
    logic [D2-1:0]  den2b;

    always_comb begin
        num2  = N2'(r_p_par) << r_frac_bits;
        mul2  = D2'(1) << r_frac_bits;
        den2a = D2'(r_p_field) + mul2;
        den2b = D2'(r_p_curf) + mul2;
    end

    logic           v2a;
    logic [N2-1:0]  q2a;
    logic [D2-1:0]  rem2a;
    logic [SW2-1:0] side2a;
    logic           v2b;
    logic [N2-1:0]  q2b;
    logic [D2-1:0]  rem2b;
    logic [31:0]    side2b;

    fcd_div_chain #(.N(N2), .D(D2), .SW(SW2)) u_div_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p_valid),
        .i_num   (num2),
        .i_den   (den2a),
        .i_side  ({r_p_err, r_p_tz, r_p_field, r_p_par}),
        .o_valid (v2a),
        .o_quo   (q2a),
        .o_rem   (rem2a),
        .o_side  (side2a)
    );

    fcd_div_chain #(.N(N2), .D(D2), .SW(32)) u_div_cur (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p_valid),
        .i_num   (num2),
        .i_den   (den2b),
        .i_side  (r_p_cur),
        .o_valid (v2b),
        .o_quo   (q2b),
        .o_rem   (rem2b),
        .o_side  (side2b)
    );

    // ---------------- result assembly ----------------
    logic          s2_err;
    logic          s2_tz;
    logic [W-1:0]  s2_field;
    logic [R-1:0]  s2_par;
    logic [63:0]   rnd64;
    logic [63:0]   cur64;
    logic [63:0]   w64;
    logic [31:0]   n_o_rounded;
    logic [31:0]   n_o_current;
    logic [31:0]   n_o_word;

    always_comb begin
        {s2_err, s2_tz, s2_field, s2_par} = side2a;
        rnd64 = 64'(q2a) + ((rem2a != '0) ? 64'd1 : 64'd0);
        cur64 = 64'(q2b) + ((rem2b != '0) ? 64'd1 : 64'd0);
        n_o_rounded = (s2_tz || s2_err) ? 32'(s2_par) : rnd64[31:0];
        n_o_current = cur64[31:0];

        // replace field, then apply enable and override bits
        w64 = 64'(side2b);
        w64 = w64 & ~(64'(mask) << r_field_shift);
        w64 = w64 | (64'(s2_field) << r_field_shift);
        if (r_uart_en) begin
            if (s2_field != '0) begin
                w64[fcd_pkg::UART_ENB_BIT] = 1'b1;
            end else begin
                w64[fcd_pkg::UART_ENB_BIT] = 1'b0;
            end
        end
        if (r_fixed_ovr && (32'(r_field_shift) >= 32'(fcd_pkg::OVERRIDE_OFFSET))) begin
            w64 = w64 | (64'd1 << (r_field_shift - 5'(fcd_pkg::OVERRIDE_OFFSET)));
        end
        n_o_word = s2_err ? side2b : w64[31:0];
    end

    // output register
    logic [15:0] r_o_field;
    logic        r_o_err;
    logic [31:0] r_o_rounded;
    logic [31:0] r_o_word;
    logic [31:0] r_o_current;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= v2a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_field   <= 16'(s2_field);
            r_o_err     <= s2_err;
            r_o_rounded <= n_o_rounded;
            r_o_word    <= n_o_word;
            r_o_current <= n_o_current;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.div_field    = r_o_field;
    assign o_out.rate_error   = r_o_err;
    assign o_out.rounded_rate = r_o_rounded;
    assign o_out.new_word     = r_o_word;
    assign o_out.current_rate = r_o_current;

    // ---------------- assertions ----------------
    a_rst_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !r_o_valid)
        else $error("output valid not cleared by reset");

    a_err_zero_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_err |-> r_o_field == '0)
        else $error("error result carries nonzero field");

    a_rows_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v2a == v2b)
        else $error("rate divider rows out of step");

endmodule
